>>> src/phd_pkg.sv
`timescale 1ns / 1ps

package phd_pkg;

  localparam int CNT_W      = 33;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_MAGIC   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VERSION = 8'd1;

  localparam logic [CNT_W-1:0] HDR_BYTES = 33'd16;

  localparam logic [3:0] HDR_VER_POS = 4'd4;
  localparam logic [3:0] HDR_FLG_POS = 4'd5;
  localparam logic [3:0] HDR_OPC_POS = 4'd6;
  localparam logic [3:0] HDR_SEQ_POS = 4'd8;
  localparam logic [3:0] HDR_LEN_POS = 4'd12;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_VERSION = 2'd2;
  localparam logic [1:0] ST_SIZE    = 2'd3;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;
  localparam int Q_CNT_W = 3;

  typedef struct packed {
    logic        item_kind;
    logic [7:0]  payload_byte;
    logic [1:0]  status;
    logic [7:0]  hdr_version;
    logic [7:0]  hdr_flags;
    logic [15:0] hdr_opcode;
    logic [31:0] sequence_id;
    logic [31:0] payload_length;
    logic        last_result;
  } res_t;

  typedef struct packed {
    logic [1:0] num;
    res_t       first;
    res_t       second;
  } push_t;

endpackage

>>> src/phd_ifs.sv
`timescale 1ns / 1ps

interface phd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_packet;

  modport source (output valid, data_byte, end_of_packet, input ready);
  modport sink   (input valid, data_byte, end_of_packet, output ready);
endinterface

interface phd_out_if;
  logic        valid;
  logic        ready;
  logic        item_kind;
  logic [7:0]  payload_byte;
  logic [1:0]  status;
  logic [7:0]  hdr_version;
  logic [7:0]  hdr_flags;
  logic [15:0] hdr_opcode;
  logic [31:0] sequence_id;
  logic [31:0] payload_length;
  logic        last_result;

  modport source (output valid, item_kind, payload_byte, status, hdr_version, hdr_flags,
                  hdr_opcode, sequence_id, payload_length, last_result, input ready);
  modport sink   (input valid, item_kind, payload_byte, status, hdr_version, hdr_flags,
                  hdr_opcode, sequence_id, payload_length, last_result, output ready);
endinterface

interface phd_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [phd_pkg::CFG_IDX_W-1:0]  index;
  logic [phd_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> src/phd_cfg_regs.sv
`timescale 1ns / 1ps

module phd_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic [phd_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [phd_pkg::CFG_DATA_W-1:0] wr_data,
  output logic [31:0]                    magic_value,
  output logic [7:0]                     protocol_version
);

  logic [31:0] magic_r;
  logic [7:0]  version_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r   <= '0;
      version_r <= '0;
    end else if (wr_en) begin
      case (wr_index)
        phd_pkg::REG_MAGIC: begin
          magic_r <= wr_data[31:0];
        end
        phd_pkg::REG_VERSION: begin
          version_r <= wr_data[7:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign magic_value      = magic_r;
  assign protocol_version = version_r;

endmodule

>>> src/phd_parser.sv
`timescale 1ns / 1ps

module phd_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_fire,
  input  logic [7:0]          data_byte,
  input  logic                end_of_packet,
  input  logic [31:0]         magic_value,
  input  logic [7:0]          protocol_version,
  output phd_pkg::push_t      push
);

  logic [phd_pkg::CNT_W-1:0] cnt_r, cnt_inc, want;
  logic [31:0] magic_r, magic_nxt;
  logic [7:0]  version_r, version_nxt;
  logic [7:0]  flags_r, flags_nxt;
  logic [15:0] opcode_r, opcode_nxt;
  logic [31:0] seq_r, seq_nxt;
  logic [31:0] len_r, len_nxt;
  logic        in_hdr, match, pay;
  logic [3:0]  pos;
  logic [1:0]  status;
  phd_pkg::res_t pay_res, ver_res;

  assign in_hdr = (cnt_r[phd_pkg::CNT_W-1:4] == '0);
  assign pos    = cnt_r[3:0];

  always_comb begin
    magic_nxt   = magic_r;
    version_nxt = version_r;
    flags_nxt   = flags_r;
    opcode_nxt  = opcode_r;
    seq_nxt     = seq_r;
    len_nxt     = len_r;
    if (in_hdr) begin
      if (pos < phd_pkg::HDR_VER_POS) begin
        magic_nxt = {magic_r[23:0], data_byte};
      end else if (pos == phd_pkg::HDR_VER_POS) begin
        version_nxt = data_byte;
      end else if (pos == phd_pkg::HDR_FLG_POS) begin
        flags_nxt = data_byte;
      end else if (pos < phd_pkg::HDR_SEQ_POS) begin
        opcode_nxt = {opcode_r[7:0], data_byte};
      end else if (pos < phd_pkg::HDR_LEN_POS) begin
        seq_nxt = {seq_r[23:0], data_byte};
      end else begin
        len_nxt = {len_r[23:0], data_byte};
      end
    end
  end

  assign cnt_inc = (&cnt_r) ? cnt_r : cnt_r + phd_pkg::CNT_W'(1);
  assign want    = {1'b0, len_nxt} + phd_pkg::HDR_BYTES;
  assign match   = (magic_nxt == magic_value) && (version_nxt == protocol_version);
  assign pay     = !in_hdr && match;

  always_comb begin
    if ((cnt_inc < phd_pkg::HDR_BYTES) || (magic_nxt != magic_value)) begin
      status = phd_pkg::ST_INVALID;
    end else if (version_nxt != protocol_version) begin
      status = phd_pkg::ST_VERSION;
    end else if (cnt_inc != want) begin
      status = phd_pkg::ST_SIZE;
    end else begin
      status = phd_pkg::ST_OK;
    end
  end

  always_comb begin
    pay_res              = '0;
    pay_res.item_kind    = phd_pkg::KIND_PAYLOAD;
    pay_res.payload_byte = data_byte;

    ver_res                = '0;
    ver_res.item_kind      = phd_pkg::KIND_VERDICT;
    ver_res.status         = status;
    ver_res.hdr_version    = version_nxt;
    ver_res.hdr_flags      = flags_nxt;
    ver_res.hdr_opcode     = opcode_nxt;
    ver_res.sequence_id    = seq_nxt;
    ver_res.payload_length = len_nxt;
    ver_res.last_result    = 1'b1;

    push.num    = in_fire ? ({1'b0, pay} + {1'b0, end_of_packet}) : 2'd0;
    push.first  = pay ? pay_res : ver_res;
    push.second = ver_res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      magic_r   <= '0;
      version_r <= '0;
      flags_r   <= '0;
      opcode_r  <= '0;
      seq_r     <= '0;
      len_r     <= '0;
    end else if (in_fire) begin
      if (end_of_packet) begin
        cnt_r     <= '0;
        magic_r   <= '0;
        version_r <= '0;
        flags_r   <= '0;
        opcode_r  <= '0;
        seq_r     <= '0;
        len_r     <= '0;
      end else begin
        cnt_r     <= cnt_inc;
        magic_r   <= magic_nxt;
        version_r <= version_nxt;
        flags_r   <= flags_nxt;
        opcode_r  <= opcode_nxt;
        seq_r     <= seq_nxt;
        len_r     <= len_nxt;
      end
    end
  end

endmodule

>>> src/phd_res_queue.sv
`timescale 1ns / 1ps

module phd_res_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  phd_pkg::push_t push,
  output logic           room,
  output logic           head_valid,
  input  logic           head_ready,
  output phd_pkg::res_t  head
);

  phd_pkg::res_t q_r [phd_pkg::Q_DEPTH];
  logic [phd_pkg::Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r, wr_ptr_b;
  logic [phd_pkg::Q_CNT_W-1:0] cnt_r, cnt_nxt;
  logic pop;

  assign head_valid = (cnt_r != '0);
  assign head       = q_r[rd_ptr_r];
  assign pop        = head_valid && head_ready;
  assign room       = (cnt_r <= phd_pkg::Q_CNT_W'(phd_pkg::Q_DEPTH - 2));
  assign wr_ptr_b   = wr_ptr_r + phd_pkg::Q_PTR_W'(1);
  assign cnt_nxt    = cnt_r + phd_pkg::Q_CNT_W'(push.num) - phd_pkg::Q_CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (push.num != 2'd0) begin
      q_r[wr_ptr_r] <= push.first;
    end
    if (push.num == 2'd2) begin
      q_r[wr_ptr_b] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + phd_pkg::Q_PTR_W'(push.num);
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + phd_pkg::Q_PTR_W'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

>>> src/packet_header_deframer_top.sv
`timescale 1ns / 1ps

// Channel  Dir  Word                                              Accepted when
// in_ch    in   data_byte, end_of_packet                          valid && ready
// out_ch   out  item_kind, payload_byte, status, header fields,   valid && ready
//               last_result
// cfg_ch   in   index, data (0 magic_value, 1 protocol_version)   valid && ready
//
// One input word per cycle while in_ch is not stalled; its results are pushed into the
// result queue and reach out_ch from its head. Header capture, counting and the verdict
// check sit in one stage feeding a four-word result queue; a final byte that is passed
// as payload pushes two words at once. in_ch stalls only while the queue holds more than two words.
// Synchronous active-low reset clears the packet state, queue and registers.
module packet_header_deframer_top (
  input  logic       clk,
  input  logic       rst_n,
  phd_in_if.sink     in_ch,
  phd_out_if.source  out_ch,
  phd_cfg_if.sink    cfg_ch
);

  logic [31:0]   magic_value;
  logic [7:0]    protocol_version;
  logic          in_fire, room;
  phd_pkg::push_t push;
  phd_pkg::res_t  head;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = room;
  assign in_fire      = in_ch.valid && room;

  phd_cfg_regs u_cfg (
    .clk              (clk),
    .rst_n            (rst_n),
    .wr_en            (cfg_ch.valid),
    .wr_index         (cfg_ch.index),
    .wr_data          (cfg_ch.data),
    .magic_value      (magic_value),
    .protocol_version (protocol_version)
  );

  phd_parser u_parser (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_fire          (in_fire),
    .data_byte        (in_ch.data_byte),
    .end_of_packet    (in_ch.end_of_packet),
    .magic_value      (magic_value),
    .protocol_version (protocol_version),
    .push             (push)
  );

  phd_res_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .room       (room),
    .head_valid (out_ch.valid),
    .head_ready (out_ch.ready),
    .head       (head)
  );

  assign out_ch.item_kind      = head.item_kind;
  assign out_ch.payload_byte   = head.payload_byte;
  assign out_ch.status         = head.status;
  assign out_ch.hdr_version    = head.hdr_version;
  assign out_ch.hdr_flags      = head.hdr_flags;
  assign out_ch.hdr_opcode     = head.hdr_opcode;
  assign out_ch.sequence_id    = head.sequence_id;
  assign out_ch.payload_length = head.payload_length;
  assign out_ch.last_result    = head.last_result;

endmodule
